[rtl/stq_pkg.sv]
// Package for the sorted timer queue: field widths, operation and result codes,
// item structs and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

    // Defaults for the top-level parameters.
    localparam int ENTRIES_DEF = 16;
    localparam int WRAP_DEF    = 1000000;

    // Fixed field widths.
    localparam int OP_W      = 3;
    localparam int ELAPSED_W = 16;
    localparam int DELAY_W   = 20;
    localparam int ID_W      = 16;
    localparam int HANDLE_W  = 4;
    localparam int KIND_W    = 3;
    localparam int COUNT_W   = 5;
    localparam int DL_W      = 24;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_TICK          = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD           = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL_HANDLE = 3'd2;
    localparam logic [OP_W-1:0] OP_CANCEL_OWNER  = 3'd3;
    localparam logic [OP_W-1:0] OP_CANCEL_ALL    = 3'd4;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOTHING   = 3'd4;

    // Register indexes on the configuration port.
    localparam logic REG_MAX_STEP = 1'b0;
    localparam logic REG_PAUSED   = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [ELAPSED_W-1:0] elapsed;
        logic [DELAY_W-1:0]   delay;
        logic [ID_W-1:0]      owner_id;
        logic [ID_W-1:0]      event_id;
        logic [HANDLE_W-1:0]  handle_in;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle_out;
        logic [ID_W-1:0]     owner_out;
        logic [ID_W-1:0]     event_out;
        logic [COUNT_W-1:0]  removed_count;
        logic                last;
    } out_item_t;

    // Source of a result loaded into the output register.
    typedef enum logic [1:0] {
        SRC_PEND    = 2'd0,
        SRC_NOTHING = 2'd1,
        SRC_ITEM    = 2'd2
    } out_src_t;

    typedef struct packed {
        logic     accept;
        logic     advance_time;
        logic     wrap_step;
        logic     scan_clear;
        logic     scan_step;
        logic     take_best;
        logic     do_add;
        logic     load_out;
        out_src_t out_src;
        logic     out_last;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            wrap_more;
        logic            scan_last;
        logic            found;
        logic            have_pend;
        logic            slot_free;
    } status_t;

endpackage

`default_nettype wire

[rtl/sorted_timer_queue.sv]
// Sorted timer queue: table of one-shot timers with add, cancel and tick items.
// Top level with configuration registers. Depends on stq_pkg, stq_ctrl, stq_datapath.
//
// Usage:
//   An item enters on in_valid/in_ready with its fields in in_item; results leave on
//   out_valid/out_ready in out_item, one or more per item, the final one with last set.
//   max_step and paused are written over the APB port (byte addresses 0 and 4).
// Sequence:
//   One item is worked at a time. An add is decoded, written to the table and then
//   reported; a paused tick or an item of unknown kind goes from decode straight to its
//   result. A cancel scans the table once, one entry a cycle. A tick advances the time,
//   removes the wrap period step by step while the time exceeds it, then scans the table;
//   it scans once per expired entry and once more.
// Reset:
//   Time is zero, the table is empty, max_step is 65535 and paused is clear.
// Stalls:
//   A result sits in the output register until taken; the block accepts the next item
//   while it waits, and holds any further result until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_queue import stq_pkg::*; #(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int WRAP_PERIOD = WRAP_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [ELAPSED_W-1:0] max_step_reg;
    logic                 paused_reg;
    cmd_t                 cmd;
    status_t              status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg <= '1;
            paused_reg   <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_MAX_STEP)
                max_step_reg <= pwdata[ELAPSED_W-1:0];
            else
                paused_reg <= pwdata[0];
        end
    end

    // Register read back.
    always_comb
    begin
        if (paddr[2] == REG_PAUSED)
            prdata = {31'b0, paused_reg};
        else
            prdata = {{(32 - ELAPSED_W){1'b0}}, max_step_reg};
    end

    assign pready = 1'b1;

    stq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .paused   (paused_reg),
        .status   (status),
        .cmd      (cmd)
    );

    stq_datapath #(
        .ENTRIES     (ENTRIES),
        .WRAP_PERIOD (WRAP_PERIOD)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (in_item),
        .max_step  (max_step_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

[rtl/stq_datapath.sv]
// Datapath of the sorted timer queue: entry table, time base, scan unit,
// pending expiry and output register. Depends on stq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stq_datapath import stq_pkg::*; #(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int WRAP_PERIOD = WRAP_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    input  wire in_item_t             in_item,
    input  wire logic [ELAPSED_W-1:0] max_step,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_item
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int TIME_W = $clog2(WRAP_PERIOD + (2 ** ELAPSED_W));
    localparam int CMP_W  = (IDX_W > HANDLE_W) ? IDX_W : HANDLE_W;

    // Entry table.
    logic [ENTRIES-1:0]   valid_reg;
    logic signed [DL_W-1:0] dl_mem [ENTRIES];
    logic [ID_W-1:0]      owner_mem [ENTRIES];
    logic [ID_W-1:0]      event_mem [ENTRIES];
    logic [IDX_W-1:0]     rank_mem [ENTRIES];
    logic [CNT_W-1:0]     count_reg;

    // Time base and pending wrap correction.
    logic [TIME_W-1:0]    time_reg;
    logic [TIME_W-1:0]    sub_reg;

    // Item and scan state.
    in_item_t             item_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic signed [DL_W-1:0] best_d_reg;
    logic [IDX_W-1:0]     best_rank_reg;
    logic [ID_W-1:0]      best_owner_reg;
    logic [ID_W-1:0]      best_event_reg;
    logic                 have_pend_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic [ID_W-1:0]      pend_owner_reg;
    logic [ID_W-1:0]      pend_event_reg;
    logic [CNT_W-1:0]     removed_reg;
    logic                 add_full_reg;
    logic [IDX_W-1:0]     add_idx_reg;

    logic                 out_valid_reg;
    out_item_t            out_item_reg;
    out_item_t            out_item_next;

    logic                 is_tick;
    logic signed [DL_W-1:0] d_eff;
    logic signed [DL_W-1:0] time_ext;
    logic                 due;
    logic                 better;
    logic                 match;
    logic                 free_en;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W-1:0]     free_rank;
    logic                 full;
    logic [IDX_W-1:0]     free_slot;
    logic                 add_en;

    assign is_tick  = (item_reg.operation == OP_TICK);
    assign time_ext = signed'(DL_W'(time_reg));
    assign d_eff    = dl_mem[idx_reg] - signed'(DL_W'(sub_reg));
    assign due      = valid_reg[idx_reg] && (d_eff <= time_ext);
    assign better   = !found_reg || (d_eff < best_d_reg) ||
                      ((d_eff == best_d_reg) && (rank_mem[idx_reg] < best_rank_reg));

    // Cancel match for the entry under the scan index.
    always_comb
    begin
        match = 1'b0;
        if (valid_reg[idx_reg])
        begin
            if (item_reg.operation == OP_CANCEL_ALL)
                match = 1'b1;
            else if (item_reg.operation == OP_CANCEL_OWNER)
                match = (owner_mem[idx_reg] == item_reg.owner_id);
            else if (item_reg.operation == OP_CANCEL_HANDLE)
                match = (CMP_W'(idx_reg) == CMP_W'(item_reg.handle_in));
        end
    end

    // One entry is freed per cycle at most: the chosen expiry or a cancel hit.
    always_comb
    begin
        free_en   = 1'b0;
        free_idx  = idx_reg;
        free_rank = rank_mem[idx_reg];
        if (cmd.take_best)
        begin
            free_en   = 1'b1;
            free_idx  = best_idx_reg;
            free_rank = best_rank_reg;
        end
        else if (cmd.scan_step && !is_tick && match)
        begin
            free_en = 1'b1;
        end
    end

    // Lowest free slot for an add.
    always_comb
    begin
        free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_slot = IDX_W'(i);
        end
    end

    assign full   = (count_reg == CNT_W'(ENTRIES));
    assign add_en = cmd.do_add && !full;

    // Valid bits and live count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (free_en)
            begin
                valid_reg[free_idx] <= 1'b0;
                count_reg           <= count_reg - CNT_W'(1);
            end
            else if (add_en)
            begin
                valid_reg[free_slot] <= 1'b1;
                count_reg            <= count_reg + CNT_W'(1);
            end
        end
    end

    // Entry payload: add writes, the first tick scan applies the wrap correction,
    // and freeing closes the gap in insertion ranks.
    always_ff @(posedge clk)
    begin
        if (add_en)
        begin
            dl_mem[free_slot]    <= time_ext + signed'(DL_W'(item_reg.delay));
            owner_mem[free_slot] <= item_reg.owner_id;
            event_mem[free_slot] <= item_reg.event_id;
            rank_mem[free_slot]  <= IDX_W'(count_reg);
        end
        if (cmd.scan_step && is_tick)
            dl_mem[idx_reg] <= d_eff;
        if (free_en)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (valid_reg[j] && (rank_mem[j] > free_rank))
                    rank_mem[j] <= rank_mem[j] - IDX_W'(1);
            end
        end
    end

    // Time base and wrap correction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            sub_reg  <= '0;
        end
        else
        begin
            if (cmd.advance_time)
            begin
                sub_reg <= '0;
                if (item_reg.elapsed < max_step)
                    time_reg <= time_reg + TIME_W'(item_reg.elapsed);
            end
            else if (cmd.wrap_step)
            begin
                time_reg <= time_reg - TIME_W'(WRAP_PERIOD);
                sub_reg  <= sub_reg + TIME_W'(WRAP_PERIOD);
            end
            else if (cmd.scan_step && (idx_reg == IDX_W'(ENTRIES - 1)))
            begin
                sub_reg <= '0;
            end
        end
    end

    // Scan control and best-candidate tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            have_pend_reg <= 1'b0;
            removed_reg   <= '0;
        end
        else
        begin
            if (cmd.advance_time)
                have_pend_reg <= 1'b0;
            else if (cmd.take_best)
                have_pend_reg <= 1'b1;

            if (cmd.scan_clear)
            begin
                idx_reg     <= '0;
                found_reg   <= 1'b0;
                removed_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (is_tick && due && better)
                    found_reg <= 1'b1;
                if (!is_tick && match)
                    removed_reg <= removed_reg + CNT_W'(1);
            end
        end
    end

    // Payload registers of the scan, pending expiry, item and add result.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= in_item;
        if (cmd.scan_step && is_tick && due && better)
        begin
            best_idx_reg   <= idx_reg;
            best_d_reg     <= d_eff;
            best_rank_reg  <= rank_mem[idx_reg];
            best_owner_reg <= owner_mem[idx_reg];
            best_event_reg <= event_mem[idx_reg];
        end
        if (cmd.take_best)
        begin
            pend_idx_reg   <= best_idx_reg;
            pend_owner_reg <= best_owner_reg;
            pend_event_reg <= best_event_reg;
        end
        if (cmd.do_add)
        begin
            add_full_reg <= full;
            add_idx_reg  <= free_slot;
        end
    end

    // Result to load into the output register.
    always_comb
    begin
        out_item_next               = '0;
        out_item_next.kind          = KIND_NOTHING;
        out_item_next.last          = cmd.out_last;
        unique case (cmd.out_src)
            SRC_PEND:
            begin
                out_item_next.kind       = KIND_EXPIRED;
                out_item_next.handle_out = HANDLE_W'(pend_idx_reg);
                out_item_next.owner_out  = pend_owner_reg;
                out_item_next.event_out  = pend_event_reg;
            end
            SRC_ITEM:
            begin
                if (item_reg.operation == OP_ADD)
                begin
                    if (add_full_reg)
                        out_item_next.kind = KIND_FULL;
                    else
                    begin
                        out_item_next.kind       = KIND_ADDED;
                        out_item_next.handle_out = HANDLE_W'(add_idx_reg);
                    end
                end
                else if ((item_reg.operation == OP_CANCEL_HANDLE) ||
                         (item_reg.operation == OP_CANCEL_OWNER) ||
                         (item_reg.operation == OP_CANCEL_ALL))
                begin
                    out_item_next.kind          = KIND_CANCELLED;
                    out_item_next.removed_count = COUNT_W'(removed_reg);
                end
            end
            default:
            begin
                out_item_next.kind = KIND_NOTHING;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign status.op        = item_reg.operation;
    assign status.wrap_more = (time_reg > TIME_W'(WRAP_PERIOD));
    assign status.scan_last = (idx_reg == IDX_W'(ENTRIES - 1));
    assign status.found     = found_reg;
    assign status.have_pend = have_pend_reg;
    assign status.slot_free = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

[rtl/stq_ctrl.sv]
// Controller of the sorted timer queue: sequences tick, add and cancel items
// over the datapath by command and status structs. Depends on stq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stq_ctrl import stq_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic    paused,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_DECODE  = 9'b000000010,
        ST_TWRAP   = 9'b000000100,
        ST_TSCAN   = 9'b000001000,
        ST_TDECIDE = 9'b000010000,
        ST_ADD     = 9'b000100000,
        ST_CSCAN   = 9'b001000000,
        ST_RESULT  = 9'b010000000,
        ST_SPARE   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_src = SRC_ITEM;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.op == OP_TICK)
                begin
                    if (paused)
                        state_next = ST_RESULT;
                    else
                    begin
                        cmd.advance_time = 1'b1;
                        state_next       = ST_TWRAP;
                    end
                end
                else if (status.op == OP_ADD)
                    state_next = ST_ADD;
                else if ((status.op == OP_CANCEL_HANDLE) ||
                         (status.op == OP_CANCEL_OWNER) ||
                         (status.op == OP_CANCEL_ALL))
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_CSCAN;
                end
                else
                    state_next = ST_RESULT;
            end
            ST_TWRAP:
            begin
                if (status.wrap_more)
                    cmd.wrap_step = 1'b1;
                else
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_TSCAN;
                end
            end
            ST_TSCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = ST_TDECIDE;
            end
            ST_TDECIDE:
            begin
                // The previous expiry goes out only once we know whether another follows.
                if (status.found && !status.have_pend)
                begin
                    cmd.take_best  = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_TSCAN;
                end
                else if (status.slot_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.found)
                    begin
                        cmd.out_src    = SRC_PEND;
                        cmd.out_last   = 1'b0;
                        cmd.take_best  = 1'b1;
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_TSCAN;
                    end
                    else
                    begin
                        cmd.out_src  = status.have_pend ? SRC_PEND : SRC_NOTHING;
                        cmd.out_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_ADD:
            begin
                cmd.do_add = 1'b1;
                state_next = ST_RESULT;
            end
            ST_CSCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.slot_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_src  = SRC_ITEM;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sim/stq_checker.sv]
// Scoreboard for the sorted timer queue: follows the item and register traffic,
// predicts every result and compares it with what the block delivers.
// Depends on stq_pkg.
`timescale 1ns / 1ps

module stq_checker import stq_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_item,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          results_owed
);

    localparam int SLOTS = ENTRIES_DEF;
    localparam longint PERIOD = WRAP_DEF;

    // Shadow copy of the timer table, the clock and the registers.
    longint          now_t;
    bit              live [SLOTS];
    longint          due_at [SLOTS];
    logic [ID_W-1:0] owner_of [SLOTS];
    logic [ID_W-1:0] event_of [SLOTS];
    int              age_rank [SLOTS];
    logic [15:0]     step_limit;
    bit              halted;

    out_item_t timer_results [$];

    // Queue one result.
    function automatic void post(logic [KIND_W-1:0] kind, int slot, logic [ID_W-1:0] own,
                                 logic [ID_W-1:0] evt, int count, bit fin);
        out_item_t r;
        r.kind          = kind;
        r.handle_out    = slot[HANDLE_W-1:0];
        r.owner_out     = own;
        r.event_out     = evt;
        r.removed_count = count[COUNT_W-1:0];
        r.last          = fin;
        timer_results.push_back(r);
    endfunction

    // Release a slot and close the gap it leaves in insertion order.
    function automatic void release_slot(int s);
        for (int j = 0; j < SLOTS; j++)
            if (live[j] && age_rank[j] > age_rank[s])
                age_rank[j]--;
        live[s] = 0;
    endfunction

    // Work out the results of one accepted item.
    function automatic void predict_timer_item(in_item_t it);
        int     fired;
        int     best;
        int     freed;
        int     slot;
        int     n_live;
        longint sub;
        fired = 0;
        freed = 0;
        case (it.operation)
            OP_TICK:
            begin
                if (halted)
                begin
                    post(KIND_NOTHING, 0, 0, 0, 0, 1);
                    return;
                end
                if (it.elapsed < step_limit)
                    now_t += it.elapsed;
                if (now_t > PERIOD)
                begin
                    sub = ((now_t - 1) / PERIOD) * PERIOD;
                    now_t -= sub;
                    for (int i = 0; i < SLOTS; i++)
                        if (live[i])
                            due_at[i] -= sub;
                end
                // Fire due timers earliest first, oldest first on a tie.
                forever
                begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!live[i] || due_at[i] > now_t)
                            continue;
                        if (best < 0 || due_at[i] < due_at[best] ||
                            (due_at[i] == due_at[best] && age_rank[i] < age_rank[best]))
                            best = i;
                    end
                    if (best < 0)
                        break;
                    post(KIND_EXPIRED, best, owner_of[best], event_of[best], 0, 0);
                    fired++;
                    release_slot(best);
                end
                if (fired == 0)
                    post(KIND_NOTHING, 0, 0, 0, 0, 1);
                else
                    timer_results[$].last = 1'b1;
            end
            OP_ADD:
            begin
                slot = -1;
                n_live = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (live[i])
                        n_live++;
                    else if (slot < 0)
                        slot = i;
                end
                if (slot < 0)
                    post(KIND_FULL, 0, 0, 0, 0, 1);
                else
                begin
                    age_rank[slot] = n_live;
                    live[slot]     = 1;
                    due_at[slot]   = now_t + it.delay;
                    owner_of[slot] = it.owner_id;
                    event_of[slot] = it.event_id;
                    post(KIND_ADDED, slot, 0, 0, 0, 1);
                end
            end
            OP_CANCEL_HANDLE:
            begin
                if (live[it.handle_in])
                begin
                    release_slot(it.handle_in);
                    freed = 1;
                end
                post(KIND_CANCELLED, 0, 0, 0, freed, 1);
            end
            OP_CANCEL_OWNER, OP_CANCEL_ALL:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (live[i] && (it.operation == OP_CANCEL_ALL ||
                                    owner_of[i] == it.owner_id))
                    begin
                        release_slot(i);
                        freed++;
                    end
                post(KIND_CANCELLED, 0, 0, 0, freed, 1);
            end
            default:
                post(KIND_NOTHING, 0, 0, 0, 0, 1);
        endcase
    endfunction

    // Compare results, then take in register writes and new items.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            now_t = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                live[i]     = 0;
                due_at[i]   = 0;
                owner_of[i] = 0;
                event_of[i] = 0;
                age_rank[i] = 0;
            end
            step_limit = 16'hFFFF;
            halted = 0;
            timer_results.delete();
            fail_count = 0;
            results_owed = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (timer_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: %p", out_item);
                end
                else
                begin
                    want = timer_results.pop_front();
                    if (out_item.kind !== want.kind || out_item.handle_out !== want.handle_out ||
                        out_item.owner_out !== want.owner_out ||
                        out_item.event_out !== want.event_out ||
                        out_item.removed_count !== want.removed_count ||
                        out_item.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result differs: expected %p, got %p", want, out_item);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_MAX_STEP)
                    step_limit = pwdata[15:0];
                else
                    halted = pwdata[0];
            end
            if (in_valid && in_ready)
                predict_timer_item(in_item);
            results_owed = timer_results.size();
        end
    end

endmodule

[sim/tb_top.sv]
// Top of the sorted timer queue testbench: clock, reset, item and register stimulus,
// and the verdict. Depends on stq_pkg, sorted_timer_queue and stq_checker.
`timescale 1ns / 1ps

module tb_top;
    import stq_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int IN_W        = $bits(in_item_t);

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_ready = 0;
    out_item_t   out_item;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          results_owed;
    int          cycles = 0;
    bit          steady = 0;
    logic        took_item = 0;

    sorted_timer_queue dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    stq_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .results_owed(results_owed)
    );

    always #10 clk = ~clk;

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sorted_timer_queue: mismatch");
            $finish;
        end
    end

    // Record each item handoff so the sender sees it at the next falling edge.
    always @(posedge clk)
        took_item <= in_valid && in_ready;

    // The receiver stalls about a quarter of the time outside the steady stretch.
    always @(negedge clk)
        out_ready <= rst_n && (steady || $urandom_range(99) >= 24);

    // Offer one item, with random idle cycles ahead of it.
    task automatic send_item(input in_item_t it);
        while (!steady && $urandom_range(99) < 24)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_item  <= it;
        do
            @(negedge clk);
        while (!took_item);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input int elapsed, input int delay,
                           input int owner, input int evt, input int handle);
        in_item_t it;
        it.operation = op;
        it.elapsed   = elapsed[ELAPSED_W-1:0];
        it.delay     = delay[DELAY_W-1:0];
        it.owner_id  = owner[ID_W-1:0];
        it.event_id  = evt[ID_W-1:0];
        it.handle_in = handle[HANDLE_W-1:0];
        send_item(it);
    endtask

    // Let the block drain, then write one register with a setup and an access phase.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        in_valid <= 0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        psel    <= 1;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        @(negedge clk);
    endtask

    // Random item: mostly adds and ticks over a few owners, some cancels and noise.
    task automatic send_random(input int tick_scale);
        in_item_t it;
        int pick;
        it = IN_W'({$urandom, $urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 36)
            it.operation = OP_ADD;
        else if (pick < 70)
            it.operation = OP_TICK;
        else if (pick < 79)
            it.operation = OP_CANCEL_HANDLE;
        else if (pick < 88)
            it.operation = OP_CANCEL_OWNER;
        else if (pick < 92)
            it.operation = OP_CANCEL_ALL;
        else
            it.operation = OP_CANCEL_ALL + OP_W'($urandom_range(3));
        case ($urandom_range(9))
            0: it.delay = '0;
            1: it.delay = DELAY_W'(1000000);
            2, 3: it.delay = DELAY_W'($urandom_range(1000000));
            default: it.delay = DELAY_W'($urandom_range(120000));
        endcase
        if ($urandom_range(3) != 0)
            it.owner_id = ID_W'($urandom_range(3));
        if ($urandom_range(2) != 0)
            it.elapsed = ELAPSED_W'($urandom_range(tick_scale));
        send_item(it);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: fill the table, overflow it, every cancel form and odd codes.
        send_op(OP_TICK, 0, 0, 0, 0, 0);
        send_op(3'd5, 16'hFFFF, 0, 0, 0, 0);
        send_op(3'd7, 0, 0, 0, 0, 0);
        send_op(OP_CANCEL_HANDLE, 0, 0, 0, 0, 15);
        send_op(OP_ADD, 0, 0, 16'hFFFF, 16'hFFFF, 0);
        send_op(OP_ADD, 0, 1000000, 0, 0, 0);
        for (int i = 0; i < 14; i++)
            send_op(OP_ADD, 0, 1000 * (i % 3), i % 4, 16'h8000 + i, 0);
        send_op(OP_ADD, 0, 5, 1, 2, 0);
        send_op(OP_TICK, 16'hFFFF, 0, 0, 0, 0);
        send_op(OP_TICK, 1500, 0, 0, 0, 0);
        send_op(OP_CANCEL_HANDLE, 0, 0, 0, 0, 1);
        send_op(OP_CANCEL_OWNER, 0, 0, 3, 0, 0);
        send_op(OP_CANCEL_ALL, 0, 0, 0, 0, 0);

        // Random traffic with default registers; one stretch runs without stalls.
        for (int n = 0; n < 110; n++)
        begin
            steady = (n >= 40 && n < 80);
            send_random(65535);
        end
        steady = 0;

        // Nothing is added to the time at all.
        write_reg(REG_MAX_STEP, 0);
        for (int n = 0; n < 20; n++)
            send_random(65535);

        // Ticks are ignored while paused.
        write_reg(REG_PAUSED, 1);
        for (int n = 0; n < 15; n++)
            send_random(65535);
        write_reg(REG_PAUSED, 0);

        // A middling step limit straddled by the elapsed amounts.
        write_reg(REG_MAX_STEP, 32'h0000_3000 | $urandom_range(16'h0FFF));
        for (int n = 0; n < 40; n++)
            send_random(20000);

        write_reg(REG_MAX_STEP, 32'h0000_FFFF);
        for (int n = 0; n < 20; n++)
            send_random(65535);
        in_valid <= 0;

        while (results_owed != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (fail_count == 0)
            $display("sorted_timer_queue: match");
        else
            $display("sorted_timer_queue: mismatch");
        $finish;
    end

endmodule
